>>> design/swsr_pkg.sv
// Package: shared constants, command codes and controller/datapath link types.
package swsr_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1) + 1;
    localparam int WORD_W        = 32;
    localparam int DIV_CNT_W     = $clog2(WORD_W);

    typedef enum logic [3:0] {
        CMD_READ     = 4'd0,
        CMD_ASSIGN   = 4'd1,
        CMD_ADD      = 4'd2,
        CMD_SUB      = 4'd3,
        CMD_MUL      = 4'd4,
        CMD_DIV      = 4'd5,
        CMD_MOD      = 4'd6,
        CMD_AND      = 4'd7,
        CMD_OR       = 4'd8,
        CMD_XOR      = 4'd9,
        CMD_SHR      = 4'd10,
        CMD_SHL      = 4'd11,
        CMD_PRE_INC  = 4'd12,
        CMD_PRE_DEC  = 4'd13,
        CMD_POST_INC = 4'd14,
        CMD_POST_DEC = 4'd15
    } cmd_t;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DIVZERO = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_en;
        logic exec;
        logic div_start;
        logic div_load;
        logic commit;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic is_div;
        logic div_zero;
        logic div_done;
        logic out_busy;
    } ctl_stat_t;

endpackage

>>> design/swsr_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface swsr_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic signed [31:0] element_index;
    logic signed [31:0] operand;

    modport source (output valid, command, element_index, operand, input ready);
    modport sink   (input valid, command, element_index, operand, output ready);
endinterface

interface swsr_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

>>> design/swsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/swsr_div.sv
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
module swsr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [31:0]        dividend,
    input  logic signed [31:0]        divisor,
    output logic                      done,
    output logic [31:0]               quotient,
    output logic [31:0]               remainder
);
    import swsr_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    dmag_reg, dmag_next;
    logic                 qneg_reg, qneg_next;
    logic                 rneg_reg, rneg_next;
    logic [WORD_W:0]      trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[WORD_W-1]};
    assign fits  = (trial >= {1'b0, dmag_reg});

    // Start on magnitudes, then shift and subtract once per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            dmag_next = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            qneg_next = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            rneg_next = dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? WORD_W'(trial - {1'b0, dmag_reg}) : trial[WORD_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    // Restore signs
    assign done      = done_reg;
    assign quotient  = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg))
        else $error("divider busy and done together");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider failed to start");

endmodule

>>> design/swsr_datapath.sv
// Datapath: request registers, table scan, arithmetic unit, store update, response register.
module swsr_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swsr_pkg::ctl_cmd_t     ctl,
    output swsr_pkg::ctl_stat_t    stat,
    input  logic [3:0]             req_command,
    input  logic signed [31:0]     req_element_index,
    input  logic signed [31:0]     req_operand,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic signed [31:0]     rsp_result_value,
    output logic [1:0]             rsp_status
);
    import swsr_pkg::*;

    cmd_t              cmd_reg;
    logic [WORD_W-1:0] key_reg, opd_reg, old_reg, nv_reg;
    logic [WORD_W-1:0] nv_comb, ret;
    logic [CNT_W-1:0]  addr_cnt_reg;
    logic              cmp_pend_reg;
    logic [IDX_W-1:0]  cmp_idx_reg, hit_idx_reg, free_idx_reg, wr_idx;
    logic              hit_reg, free_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic              scan_issue;
    logic [WORD_W-1:0] key_rdata, data_rdata;
    logic              ram_we;
    logic              div_done;
    logic [WORD_W-1:0] div_q, div_r;
    logic              out_valid_reg;
    logic [WORD_W-1:0] result_reg;
    logic [1:0]        status_reg;

    assign scan_issue = ctl.scan_en && (addr_cnt_reg < CNT_W'(TABLE_ENTRIES));
    assign wr_idx     = hit_reg ? hit_idx_reg : free_idx_reg;

    swsr_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (key_reg),
        .raddr (addr_cnt_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    swsr_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (nv_reg),
        .raddr (addr_cnt_reg[IDX_W-1:0]),
        .rdata (data_rdata)
    );

    swsr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (old_reg),
        .divisor   (opd_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Capture request and run the table scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_cnt_reg <= '0;
            cmp_pend_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end
        else if (ctl.load)
        begin
            addr_cnt_reg <= '0;
            cmp_pend_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end
        else if (ctl.scan_en)
        begin
            cmp_pend_reg <= scan_issue;
            if (scan_issue)
            begin
                addr_cnt_reg <= addr_cnt_reg + 1'b1;
            end
            if (cmp_pend_reg)
            begin
                if (valid_reg[cmp_idx_reg] && !hit_reg && key_rdata == key_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!valid_reg[cmp_idx_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd_t'(req_command);
            key_reg <= req_element_index;
            opd_reg <= req_operand;
            old_reg <= '0;
        end
        else if (ctl.scan_en && cmp_pend_reg)
        begin
            if (valid_reg[cmp_idx_reg] && !hit_reg && key_rdata == key_reg)
            begin
                hit_idx_reg <= cmp_idx_reg;
                old_reg     <= data_rdata;
            end
            if (!valid_reg[cmp_idx_reg] && !free_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
        if (scan_issue)
        begin
            cmp_idx_reg <= addr_cnt_reg[IDX_W-1:0];
        end
        if (ctl.exec)
        begin
            nv_reg <= nv_comb;
        end
        else if (ctl.div_load)
        begin
            nv_reg <= (cmd_reg == CMD_DIV) ? div_q : div_r;
        end
    end

    // Apply the command to the old value
    always_comb
    begin
        unique case (cmd_reg)
            CMD_READ:     nv_comb = old_reg;
            CMD_ASSIGN:   nv_comb = opd_reg;
            CMD_ADD:      nv_comb = old_reg + opd_reg;
            CMD_SUB:      nv_comb = old_reg - opd_reg;
            CMD_MUL:      nv_comb = old_reg * opd_reg;
            CMD_DIV:      nv_comb = old_reg;
            CMD_MOD:      nv_comb = old_reg;
            CMD_AND:      nv_comb = old_reg & opd_reg;
            CMD_OR:       nv_comb = old_reg | opd_reg;
            CMD_XOR:      nv_comb = old_reg ^ opd_reg;
            CMD_SHR:      nv_comb = WORD_W'($signed(old_reg) >>> opd_reg[4:0]);
            CMD_SHL:      nv_comb = old_reg << opd_reg[4:0];
            CMD_PRE_INC:  nv_comb = old_reg + 1'b1;
            CMD_PRE_DEC:  nv_comb = old_reg - 1'b1;
            CMD_POST_INC: nv_comb = old_reg + 1'b1;
            CMD_POST_DEC: nv_comb = old_reg - 1'b1;
            default:      nv_comb = old_reg;
        endcase
    end

    assign ret = (cmd_reg == CMD_POST_INC || cmd_reg == CMD_POST_DEC) ? old_reg : nv_reg;

    // Write the store only for a non-read, non-faulting, non-zero value with a place to go
    assign ram_we = ctl.commit && !stat.div_zero && cmd_reg != CMD_READ
                    && nv_reg != '0 && (hit_reg || free_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.commit && !stat.div_zero && cmd_reg != CMD_READ)
        begin
            if (nv_reg == '0)
            begin
                if (hit_reg)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
            else if (!hit_reg && free_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    // Response register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            priority if (stat.div_zero)
            begin
                result_reg <= '0;
                status_reg <= STAT_DIVZERO;
            end
            else if (cmd_reg == CMD_READ)
            begin
                result_reg <= old_reg;
                status_reg <= STAT_OK;
            end
            else if (nv_reg != '0 && !hit_reg && !free_reg)
            begin
                result_reg <= '0;
                status_reg <= STAT_FULL;
            end
            else
            begin
                result_reg <= ret;
                status_reg <= STAT_OK;
            end
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_result_value = result_reg;
    assign rsp_status       = status_reg;

    assign stat.scan_done = (addr_cnt_reg == CNT_W'(TABLE_ENTRIES)) && !cmp_pend_reg;
    assign stat.is_div    = (cmd_reg == CMD_DIV) || (cmd_reg == CMD_MOD);
    assign stat.div_zero  = stat.is_div && (opd_reg == '0);
    assign stat.div_done  = div_done;
    assign stat.out_busy  = out_valid_reg && !rsp_ready;

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid_reg)
        else $error("response not raised after commit");
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != STAT_OK |-> result_reg == '0)
        else $error("faulting response carries a nonzero value");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> !stat.out_busy)
        else $error("commit over a pending response");

endmodule

>>> design/swsr_ctrl.sv
// Controller: sequences accept, table scan, execute, divide wait and commit.
module swsr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    output swsr_pkg::ctl_cmd_t     ctl,
    input  swsr_pkg::ctl_stat_t    stat
);
    import swsr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_DIVW   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_SPARE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_div && !stat.div_zero)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
                else
                begin
                    ctl.exec   = 1'b1;
                    state_next = S_COMMIT;
                end
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    ctl.div_load = 1'b1;
                    state_next   = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!stat.out_busy)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");
    a_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> state_reg == S_SCAN)
        else $error("accept not followed by scan");
    a_divload_div: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_load |-> stat.is_div)
        else $error("divider result taken for a non-divide command");

endmodule

>>> design/sparse_word_store_rmw.sv
// Sparse word store: request item in, looked up in a 16-entry key table,
// updated and answered with one response item.
// Channels: req carries command, element_index and operand; rsp carries
// result_value and status. Both use valid/ready; an item moves at a clock
// edge where both are high.
// Steps: accept, then a table scan through the key/data RAM read port,
// then execute and commit. Divide and modulo start the bit-serial divider
// in place of execute and wait for it before commit.
// One item is in work at a time; req.ready is high only between items.
// The response sits in an output register, so the next item is accepted
// while an earlier response is still waiting to be taken.
// A stalled rsp holds its item; a finished item waits in commit until the
// output register is free.
// Reset (rst_n low, asynchronous) empties the table by clearing the valid
// bits and drops any pending response; no clearing pass is needed.
module sparse_word_store_rmw (
    input  logic       clk,
    input  logic       rst_n,
    swsr_req_if.sink   req,
    swsr_rsp_if.source rsp
);
    import swsr_pkg::*;

    ctl_cmd_t  ctl;
    ctl_stat_t stat;

    swsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .ctl       (ctl),
        .stat      (stat)
    );

    swsr_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .stat              (stat),
        .req_command       (req.command),
        .req_element_index (req.element_index),
        .req_operand       (req.operand),
        .rsp_valid         (rsp.valid),
        .rsp_ready         (rsp.ready),
        .rsp_result_value  (rsp.result_value),
        .rsp_status        (rsp.status)
    );

endmodule
